@@ rtl/jacobi_stencil_sweep_assert.svh @@
// assertion macros shared by the stencil sweep rtl
// no dependencies; files take it by include after their imports
`ifndef JACOBI_STENCIL_SWEEP_ASSERT_SVH
`define JACOBI_STENCIL_SWEEP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JSW_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stencil sweep assertion failed");

// next-cycle implication, disabled during reset
`define JSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stencil sweep assertion failed");

`endif

@@ rtl/jsw_pkg.sv @@
// shared constants, register codes and stage control type for the stencil sweep
// no dependencies
`timescale 1ns / 1ps

package jsw_pkg;

	localparam int MAX_ROW    = 1024;
	localparam int PTR_W      = $clog2(MAX_ROW);
	localparam int LEN_W      = 11;
	localparam int ROWS_W     = 16;
	localparam int EFF_W      = (LEN_W > PTR_W + 1) ? LEN_W : PTR_W + 1;
	localparam int VALUE_W    = 32;
	localparam int SUM4_W     = VALUE_W + 2;
	localparam int DIFF_W     = VALUE_W + 1;
	localparam int RESID_W    = 64;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int MIN_LEN    = 3;
	localparam int MIN_ROWS   = 3;
	localparam int FIRST_ROW  = 2;

	localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = LEN_W'(1024);
	localparam logic [ROWS_W-1:0] ROW_COUNT_RESET  = ROWS_W'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(1);

	typedef struct packed {
		logic valid;
		logic done;
	} jsw_ctl_t;

endpackage

@@ rtl/jsw_if.sv @@
// valid/ready stream interfaces for grid cells and relaxed results
// depends on jsw_pkg
`timescale 1ns / 1ps

interface jsw_cell_if import jsw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

interface jsw_result_if import jsw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] new_value;
	logic [RESID_W-1:0] residual_sum;
	logic               sweep_done;

	modport source (output valid, output new_value, output residual_sum, output sweep_done,
		input ready);
	modport sink (input valid, input new_value, input residual_sum, input sweep_done,
		output ready);
endinterface

@@ rtl/jsw_cell.sv @@
// one window cell: holds a middle-row value and takes its neighbor's value, or the alternate value, on load
// depends on jsw_pkg
`timescale 1ns / 1ps

module jsw_cell import jsw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               take_alt,
	input  logic [VALUE_W-1:0] nbr_value,
	input  logic [VALUE_W-1:0] alt_value,
	output logic [VALUE_W-1:0] value_q,
	output logic [VALUE_W-1:0] next_value
);

	assign next_value = take_alt ? alt_value : nbr_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (load) begin
			value_q <= next_value;
		end
	end

endmodule

@@ rtl/jsw_line_buf.sv @@
// two row line buffers with one write and registered prefetch reads
// depends on jsw_pkg
`timescale 1ns / 1ps

module jsw_line_buf import jsw_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  logic [PTR_W-1:0]   wr_addr,
	input  logic [VALUE_W-1:0] mid_wr_data,
	input  logic [VALUE_W-1:0] up_wr_data,
	input  logic [PTR_W-1:0]   rd_addr0,
	input  logic [PTR_W-1:0]   rd_addr1,
	output logic [VALUE_W-1:0] mid_rd0_q,
	output logic [VALUE_W-1:0] mid_rd1_q,
	output logic [VALUE_W-1:0] up_rd_q
);

	logic [VALUE_W-1:0] mid_mem [MAX_ROW];
	logic [VALUE_W-1:0] up_mem [MAX_ROW];

	// reads fetch the operands of the next column; addresses never match the write
	always_ff @(posedge clk) begin
		if (load) begin
			mid_mem[wr_addr] <= mid_wr_data;
			up_mem[wr_addr]  <= up_wr_data;
			mid_rd0_q        <= mid_mem[rd_addr0];
			mid_rd1_q        <= mid_mem[rd_addr1];
			up_rd_q          <= up_mem[rd_addr0];
		end
	end

endmodule

@@ rtl/jsw_residual.sv @@
// relaxation datapath: four-point sum, floor average, difference, square,
// saturating residual accumulation and output register; depends on jsw_pkg
`timescale 1ns / 1ps

module jsw_residual import jsw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               clear,
	input  jsw_ctl_t           ctl,
	input  logic [VALUE_W-1:0] left_value,
	input  logic [VALUE_W-1:0] right_value,
	input  logic [VALUE_W-1:0] top_value,
	input  logic [VALUE_W-1:0] bottom_value,
	input  logic [VALUE_W-1:0] center_value,
	output logic               out_valid_q,
	output logic [VALUE_W-1:0] new_value_q,
	output logic [RESID_W-1:0] residual_q,
	output logic               done_q
);

`include "jacobi_stencil_sweep_assert.svh"

	jsw_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic [SUM4_W-1:0]  sum_s1;
	logic [VALUE_W-1:0] center_s1;
	logic [VALUE_W-1:0] nv_s2, nv_s3, nv_s4;
	logic [DIFF_W-1:0]  diff_s2, mag_s3;
	logic [RESID_W-1:0] sq_s4;
	logic [RESID_W-1:0] acc_q;

	logic [SUM4_W-1:0]  sum4;
	logic [VALUE_W-1:0] nv;
	logic [RESID_W-1:0] prod;
	logic [RESID_W:0]   acc_wide;
	logic [RESID_W-1:0] acc_next;
	logic               acc_grow;

	assign sum4 = SUM4_W'($signed(left_value)) + SUM4_W'($signed(right_value))
		+ SUM4_W'($signed(top_value)) + SUM4_W'($signed(bottom_value));

	// floor of sum/4 is the upper bits of the two's complement sum
	assign nv = sum_s1[SUM4_W-1:2];

	assign prod = mag_s3[VALUE_W-1:0] * mag_s3[VALUE_W-1:0];

	assign acc_wide = {1'b0, acc_q} + {1'b0, sq_s4};
	assign acc_next = acc_wide[RESID_W] ? '1 : acc_wide[RESID_W-1:0];

	assign acc_grow = !clear && adv && ctl_s4.valid && !ctl_s4.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s1      <= ctl;
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			out_valid_q <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1    <= sum4;
			center_s1 <= center_value;
			nv_s2     <= nv;
			diff_s2   <= {nv[VALUE_W-1], nv} - {center_s1[VALUE_W-1], center_s1};
			nv_s3     <= nv_s2;
			mag_s3    <= diff_s2[DIFF_W-1] ? (~diff_s2 + DIFF_W'(1)) : diff_s2;
			nv_s4     <= nv_s3;
			// a magnitude of 2^32 squares past the top of the sum
			sq_s4     <= mag_s3[DIFF_W-1] ? '1 : prod;
			if (ctl_s4.valid) begin
				new_value_q <= nv_s4;
				residual_q  <= acc_next;
				done_q      <= ctl_s4.done;
			end
		end
	end

	// running residual restarts after the last cell of a sweep and on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (adv && ctl_s4.valid) begin
			acc_q <= ctl_s4.done ? '0 : acc_next;
		end
	end

	`JSW_ASSERT_NEXT(acc_restart_a, clk, arst_n, adv && ctl_s4.valid && ctl_s4.done, acc_q == '0)
	`JSW_ASSERT_NEXT(acc_monotone_a, clk, arst_n, acc_grow, acc_q >= $past(acc_q))
	`JSW_ASSERT_NEXT(out_hold_a, clk, arst_n, out_valid_q && !adv, $stable(new_value_q))

endmodule

@@ rtl/jacobi_stencil_sweep.sv @@
// top level of the five-point jacobi relaxation sweep
// depends on jsw_pkg, jsw_if, jsw_cell, jsw_line_buf, jsw_residual
//
//  port       dir    handshake      payload
//  cells      sink   valid/ready    cell_value (q16.16, raster order)
//  results    source valid/ready    new_value, residual_sum, sweep_done
//  write_en   in     none           reg_index, write_data
//
// one cell per cycle while results are not stalled; a result passes stages s1 to s4 and the output register
// the rate is set by one line buffer write and three prefetch reads per cell
// a stalled result freezes the whole pipeline and deasserts cells.ready
// reset clears counters, window and pipeline valids; no clearing pass
`timescale 1ns / 1ps

module jacobi_stencil_sweep import jsw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write_en,
	input  logic [CFG_IDX_W-1:0]  reg_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	jsw_cell_if.sink              cells,
	jsw_result_if.source          results
);

`include "jacobi_stencil_sweep_assert.svh"

	logic [LEN_W-1:0]  row_length_q;
	logic [ROWS_W-1:0] row_count_q;
	logic [EFF_W-1:0]  len_eff;
	logic [ROWS_W-1:0] rows_eff;

	logic [PTR_W-1:0]  col_q, col_next, rd_addr1;
	logic [ROWS_W-1:0] row_q;
	logic [EFF_W-1:0]  col_ext, nxt_ext;
	logic              col_last, row_last, sweep_end;

	logic adv, accept, produce, done;

	logic [VALUE_W-1:0] mid_rd0, mid_rd1, up_rd;
	logic [VALUE_W-1:0] win1_q, win2_q;
	logic [VALUE_W-1:0] win1_next, win2_next;

	jsw_ctl_t ctl;
	logic     out_valid;

	always_comb begin
		len_eff = EFF_W'(row_length_q);
		if (row_length_q < LEN_W'(MIN_LEN)) begin
			len_eff = EFF_W'(MIN_LEN);
		end else if (EFF_W'(row_length_q) > EFF_W'(MAX_ROW)) begin
			len_eff = EFF_W'(MAX_ROW);
		end
	end

	assign rows_eff = (row_count_q < ROWS_W'(MIN_ROWS)) ? ROWS_W'(MIN_ROWS) : row_count_q;

	assign col_ext  = EFF_W'(col_q);
	assign col_last = (col_ext + EFF_W'(1)) >= len_eff;
	assign row_last = ({1'b0, row_q} + (ROWS_W + 1)'(1)) >= {1'b0, rows_eff};
	assign col_next = col_last ? '0 : col_q + PTR_W'(1);
	assign nxt_ext  = EFF_W'(col_next);
	// right neighbor of the next column; past the row end it is never used
	assign rd_addr1 = ((nxt_ext + EFF_W'(1)) >= len_eff) ? '0 : col_next + PTR_W'(1);

	assign produce = (row_q >= ROWS_W'(FIRST_ROW)) && (col_q != '0)
		&& ((col_ext + EFF_W'(2)) <= len_eff);
	assign done = ({1'b0, row_q} + (ROWS_W + 1)'(1) == {1'b0, rows_eff})
		&& ((col_ext + EFF_W'(2)) == len_eff);

	assign adv          = !out_valid || results.ready;
	assign accept       = cells.valid && adv;
	assign cells.ready  = adv;
	assign results.valid = out_valid;
	assign sweep_end    = accept && col_last && row_last;

	assign ctl.valid = accept && produce;
	assign ctl.done  = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
			row_count_q  <= ROW_COUNT_RESET;
			col_q        <= '0;
			row_q        <= '0;
		end else if (write_en) begin
			// any write restarts the sweep
			if (reg_index == REG_ROW_LENGTH) begin
				row_length_q <= write_data[LEN_W-1:0];
			end else if (reg_index == REG_ROW_COUNT) begin
				row_count_q <= write_data[ROWS_W-1:0];
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			if (col_last) begin
				row_q <= row_last ? '0 : row_q + ROWS_W'(1);
			end
		end
	end

	// middle-row window, shifting left one column per transaction
	jsw_cell u_win2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.take_alt   (1'b0),
		.nbr_value  (mid_rd1),
		.alt_value  (mid_rd1),
		.value_q    (win2_q),
		.next_value (win2_next)
	);

	// at a row start the center comes straight from the buffer
	// the held center is the left neighbor of the next column
	jsw_cell u_win1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.take_alt   (col_q == '0),
		.nbr_value  (win2_q),
		.alt_value  (mid_rd0),
		.value_q    (win1_q),
		.next_value (win1_next)
	);

	jsw_line_buf u_line_buf (
		.clk         (clk),
		.load        (accept),
		.wr_addr     (col_q),
		.mid_wr_data (cells.cell_value),
		.up_wr_data  (win1_next),
		.rd_addr0    (col_next),
		.rd_addr1    (rd_addr1),
		.mid_rd0_q   (mid_rd0),
		.mid_rd1_q   (mid_rd1),
		.up_rd_q     (up_rd)
	);

	jsw_residual u_residual (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.clear        (write_en),
		.ctl          (ctl),
		.left_value   (win1_q),
		.right_value  (win2_next),
		.top_value    (up_rd),
		.bottom_value (cells.cell_value),
		.center_value (win1_next),
		.out_valid_q  (out_valid),
		.new_value_q  (results.new_value),
		.residual_q   (results.residual_sum),
		.done_q       (results.sweep_done)
	);

	`JSW_ASSERT(col_in_row_a, clk, arst_n, 1'b1, col_ext < len_eff)
	`JSW_ASSERT_NEXT(sweep_wrap_a, clk, arst_n, sweep_end, (col_q == '0) && (row_q == '0))
	`JSW_ASSERT(window_frozen_a, clk, arst_n, cells.valid && !adv, !ctl.valid)

endmodule
